// ----- rtl/core/aet_pkg.sv -----
// Shared constants, codes and control structs of the allocation extent tracker.
// No dependencies; every other file of the block but aet_ram imports it.
package aet_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int ADDR_W        = 48;
   localparam int SIZE_W        = 40;
   localparam int TOTAL_W       = 48;
   localparam int COUNT_W       = 7;
   localparam int ALLOC_W       = 32;
   localparam int PCT_W         = 7;
   localparam int STATUS_W      = 2;
   localparam int OP_W          = 2;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int SCAN_W        = $clog2(TABLE_ENTRIES + 1);
   localparam int SLOT_W        = ADDR_W + SIZE_W;
   // total * 100 needs seven more bits than the total itself
   localparam int PROD_W        = TOTAL_W + 7;
   localparam int DIV_STEPS     = 7;
   localparam int DIV_CNT_W     = 3;
   localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNTRACKED = 2'd2;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic apply;
      logic water;
      logic pct_start;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- rtl/core/aet_if.sv -----
// Channel interfaces of the tracker: request, result and register write.
// Depends on aet_pkg for the field widths.
interface aet_req_if;
   import aet_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [ADDR_W-1:0]   extent_address;
   logic [SIZE_W-1:0]   extent_bytes;
   logic                pinned;
   modport source (output valid, operation, extent_address, extent_bytes, pinned,
                   input ready);
   modport sink (input valid, operation, extent_address, extent_bytes, pinned,
                 output ready);
endinterface

interface aet_rsp_if;
   import aet_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TOTAL_W-1:0]  allocated_bytes;
   logic [COUNT_W-1:0]  allocated_buffers;
   logic [TOTAL_W-1:0]  high_water_bytes;
   logic [TOTAL_W-1:0]  low_water_bytes;
   logic [SIZE_W-1:0]   min_extent_bytes;
   logic [SIZE_W-1:0]   max_extent_bytes;
   logic [ALLOC_W-1:0]  alloc_count;
   logic [PCT_W-1:0]    allocated_percent;
   logic [TOTAL_W-1:0]  pinned_bytes;
   logic [COUNT_W-1:0]  pinned_buffers;
   modport source (output valid, status, allocated_bytes, allocated_buffers,
                   high_water_bytes, low_water_bytes, min_extent_bytes,
                   max_extent_bytes, alloc_count, allocated_percent,
                   pinned_bytes, pinned_buffers, input ready);
   modport sink (input valid, status, allocated_bytes, allocated_buffers,
                 high_water_bytes, low_water_bytes, min_extent_bytes,
                 max_extent_bytes, alloc_count, allocated_percent,
                 pinned_bytes, pinned_buffers, output ready);
endinterface

interface aet_csr_if;
   import aet_pkg::*;
   logic                valid;
   logic                ready;
   logic [TOTAL_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/aet_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module aet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/aet_datapath.sv -----
// Datapath of the tracker: slot table, table scan, statistics, percent divider
// and the result register. Depends on aet_pkg, aet_if and aet_ram.
module aet_datapath (
   input  logic                  clock,
   input  logic                  reset,
   aet_req_if.sink               req_bus,
   aet_rsp_if.source             rsp_bus,
   aet_csr_if.sink               csr_bus,
   input  aet_pkg::ctrl_cmd_type cmd,
   output aet_pkg::dp_status_type stat
);
   import aet_pkg::*;

   // captured request
   logic [OP_W-1:0]     op_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [SIZE_W-1:0]   bytes_ff;
   logic                pin_ff;

   logic [TOTAL_W-1:0]  space_ff;

   // slot flags
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] pinned_ff, pinned_in;

   // scan
   logic [SCAN_W-1:0]   rd_idx_ff;
   logic                cmp_vld_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic                hit_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [SIZE_W-1:0]   hit_bytes_ff;
   logic                free_found_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic [SLOT_W-1:0]   ram_rd_data;

   // statistics
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  bc_ff, bc_in;
   logic [TOTAL_W-1:0]  high_ff;
   logic [TOTAL_W-1:0]  low_ff, low_in;
   logic [SIZE_W-1:0]   small_ff, small_in;
   logic [SIZE_W-1:0]   large_ff, large_in;
   logic [ALLOC_W-1:0]  areq_ff, areq_in;
   logic [TOTAL_W-1:0]  ptot_ff, ptot_in;
   logic [COUNT_W-1:0]  pc_ff, pc_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                water_ff, water_in;
   logic [TOTAL_W-1:0]  high_in;

   // table write
   logic                ram_wr_en;
   logic [IDX_W-1:0]    slot_idx;

   // percent divider
   logic [PROD_W-1:0]   rem_ff;
   logic [PROD_W-1:0]   dv_ff;
   logic [PCT_W-1:0]    quo_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [PROD_W-1:0]   product;
   logic [PROD_W-1:0]   space_x128;
   logic [PCT_W-1:0]    pct_final;

   // result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] r_status_ff;
   logic [TOTAL_W-1:0]  r_total_ff, r_high_ff, r_low_ff, r_ptot_ff;
   logic [COUNT_W-1:0]  r_bc_ff, r_pc_ff;
   logic [SIZE_W-1:0]   r_small_ff, r_large_ff;
   logic [ALLOC_W-1:0]  r_areq_ff;
   logic [PCT_W-1:0]    r_pct_ff;

   aet_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_idx),
      .wr_data ({addr_ff, bytes_ff}),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready = cmd.load;
   assign csr_bus.ready = 1'b1;

   assign slot_idx = hit_ff ? hit_idx_ff : free_idx_ff;

   // Event update: the next values of the statistics follow from the scan, or are reset by clear.
   always_comb begin
      logic [TOTAL_W-1:0] old_b;
      logic [TOTAL_W-1:0] new_b;
      logic               old_pin;
      old_b     = hit_ff ? TOTAL_W'(hit_bytes_ff) : '0;
      new_b     = TOTAL_W'(bytes_ff);
      old_pin   = hit_ff & pinned_ff[hit_idx_ff];
      valid_in  = valid_ff;
      pinned_in = pinned_ff;
      total_in  = total_ff;
      bc_in     = bc_ff;
      low_in    = low_ff;
      small_in  = small_ff;
      large_in  = large_ff;
      areq_in   = areq_ff;
      ptot_in   = ptot_ff;
      pc_in     = pc_ff;
      status_in = ST_DONE;
      water_in  = 1'b0;
      ram_wr_en = 1'b0;
      case (op_ff)
         OP_ALLOC: begin
            if (!hit_ff && !free_found_ff) begin
               status_in = ST_FULL;
            end else begin
               ram_wr_en           = cmd.apply;
               valid_in[slot_idx]  = 1'b1;
               pinned_in[slot_idx] = pin_ff;
               total_in = total_ff - old_b + new_b;
               ptot_in  = ptot_ff - (old_pin ? old_b : '0) + (pin_ff ? new_b : '0);
               pc_in    = pc_ff - COUNT_W'(old_pin) + COUNT_W'(pin_ff);
               bc_in    = bc_ff + COUNT_W'(!hit_ff);
               areq_in  = areq_ff + 1'b1;
               if (bytes_ff < small_ff) small_in = bytes_ff;
               if (bytes_ff > large_ff) large_in = bytes_ff;
               water_in = 1'b1;
            end
         end
         OP_FREE: begin
            if (!hit_ff) begin
               status_in = ST_UNTRACKED;
            end else begin
               valid_in[hit_idx_ff]  = 1'b0;
               pinned_in[hit_idx_ff] = 1'b0;
               total_in = total_ff - old_b;
               ptot_in  = ptot_ff - (old_pin ? old_b : '0);
               pc_in    = pc_ff - COUNT_W'(old_pin);
               bc_in    = bc_ff - 1'b1;
               water_in = 1'b1;
            end
         end
         OP_CLEAR: begin
            valid_in  = '0;
            pinned_in = '0;
            total_in  = '0;
            bc_in     = '0;
            low_in    = '1;
            small_in  = '1;
            large_in  = '0;
            areq_in   = '0;
            ptot_in   = '0;
            pc_in     = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      high_in = high_ff;
      if (water_ff && total_ff > high_ff) high_in = total_ff;
   end

   // total * 100 as shifts and adds
   assign product    = (PROD_W'(total_ff) << 6) + (PROD_W'(total_ff) << 5)
                       + (PROD_W'(total_ff) << 2);
   assign space_x128 = {space_ff, 7'd0};
   assign pct_final  = (quo_ff > PCT_MAX) ? PCT_MAX : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         space_ff      <= '0;
         valid_ff      <= '0;
         pinned_ff     <= '0;
         total_ff      <= '0;
         bc_ff         <= '0;
         high_ff       <= '0;
         low_ff        <= '1;
         small_ff      <= '1;
         large_ff      <= '0;
         areq_ff       <= '0;
         ptot_ff       <= '0;
         pc_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_idx_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         water_ff      <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         if (csr_bus.valid) begin
            space_ff <= csr_bus.data;
         end
         if (cmd.load) begin
            op_ff         <= req_bus.operation;
            addr_ff       <= req_bus.extent_address;
            bytes_ff      <= req_bus.extent_bytes;
            pin_ff        <= req_bus.pinned;
            rd_idx_ff     <= '0;
            cmp_vld_ff    <= 1'b0;
            hit_ff        <= 1'b0;
            free_found_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (rd_idx_ff != SCAN_W'(TABLE_ENTRIES)) begin
               rd_idx_ff  <= rd_idx_ff + 1'b1;
               cmp_vld_ff <= 1'b1;
               cmp_idx_ff <= rd_idx_ff[IDX_W-1:0];
            end else begin
               cmp_vld_ff <= 1'b0;
            end
            // RAM data now belongs to the entry issued in the previous cycle.
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff] && !hit_ff
                   && ram_rd_data[SLOT_W-1:SIZE_W] == addr_ff) begin
                  hit_ff       <= 1'b1;
                  hit_idx_ff   <= cmp_idx_ff;
                  hit_bytes_ff <= ram_rd_data[SIZE_W-1:0];
               end
               if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= cmp_idx_ff;
               end
            end
         end
         if (cmd.apply) begin
            valid_ff  <= valid_in;
            pinned_ff <= pinned_in;
            total_ff  <= total_in;
            bc_ff     <= bc_in;
            low_ff    <= low_in;
            small_ff  <= small_in;
            large_ff  <= large_in;
            areq_ff   <= areq_in;
            ptot_ff   <= ptot_in;
            pc_ff     <= pc_in;
            status_ff <= status_in;
            water_ff  <= water_in;
            if (op_ff == OP_CLEAR) begin
               high_ff <= '0;
            end
         end
         if (cmd.water) begin
            high_ff <= high_in;
            if (water_ff && total_ff < low_ff) low_ff <= total_ff;
         end
         if (cmd.pct_start) begin
            rem_ff <= product;
            dv_ff  <= {1'b0, space_ff, 6'd0};
            quo_ff <= '0;
            if (space_ff == '0) begin
               div_cnt_ff <= '0;
            end else if (product >= space_x128) begin
               quo_ff     <= PCT_MAX;
               div_cnt_ff <= '0;
            end else begin
               div_cnt_ff <= DIV_CNT_W'(DIV_STEPS);
            end
         end
         if (cmd.div_step) begin
            if (rem_ff >= dv_ff) begin
               rem_ff <= rem_ff - dv_ff;
               quo_ff <= {quo_ff[PCT_W-2:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[PCT_W-2:0], 1'b0};
            end
            dv_ff      <= dv_ff >> 1;
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            r_status_ff  <= status_ff;
            r_total_ff   <= total_ff;
            r_bc_ff      <= bc_ff;
            r_high_ff    <= high_ff;
            r_low_ff     <= low_ff;
            r_small_ff   <= small_ff;
            r_large_ff   <= large_ff;
            r_areq_ff    <= areq_ff;
            r_pct_ff     <= pct_final;
            r_ptot_ff    <= ptot_ff;
            r_pc_ff      <= pc_ff;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.scan_done = (rd_idx_ff == SCAN_W'(TABLE_ENTRIES)) && !cmp_vld_ff;
   assign stat.div_done  = (div_cnt_ff == '0);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = r_status_ff;
   assign rsp_bus.allocated_bytes   = r_total_ff;
   assign rsp_bus.allocated_buffers = r_bc_ff;
   assign rsp_bus.high_water_bytes  = r_high_ff;
   assign rsp_bus.low_water_bytes   = r_low_ff;
   assign rsp_bus.min_extent_bytes  = r_small_ff;
   assign rsp_bus.max_extent_bytes  = r_large_ff;
   assign rsp_bus.alloc_count       = r_areq_ff;
   assign rsp_bus.allocated_percent = r_pct_ff;
   assign rsp_bus.pinned_bytes      = r_ptot_ff;
   assign rsp_bus.pinned_buffers    = r_pc_ff;

   // The buffer count must always equal the number of occupied slots.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'(bc_ff) == $countones(valid_ff))
      else $error("buffer count differs from occupied slots");

   a_pinned_count: assert property (@(posedge clock) disable iff (reset)
      32'(pc_ff) == $countones(pinned_ff & valid_ff))
      else $error("pinned count differs from pinned slots");

   a_pinned_subset: assert property (@(posedge clock) disable iff (reset)
      (pinned_ff & ~valid_ff) == '0)
      else $error("pinned mark on a free slot");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> r_pct_ff <= PCT_MAX)
      else $error("percent above saturation");
endmodule

// ----- rtl/core/aet_ctrl.sv -----
// Sequencer of the tracker: steps each request through scan (allocate and free only), update,
// watermarks and the percent divider. Depends on aet_pkg.
module aet_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [aet_pkg::OP_W-1:0] req_operation,
   input  aet_pkg::dp_status_type stat,
   output aet_pkg::ctrl_cmd_type  cmd
);
   import aet_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_APPLY, S_WATER, S_PCT, S_DIV, S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = 1'b1;
            if (req_valid) begin
               // Only allocate and free need the table scan.
               if (req_operation == OP_ALLOC || req_operation == OP_FREE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_WATER;
         end
         S_WATER: begin
            cmd.water = 1'b1;
            state_in  = S_PCT;
         end
         S_PCT: begin
            cmd.pct_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_OUT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_IDLE)
      else $error("result issued without returning to idle");

   a_apply_once: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> !cmd.apply)
      else $error("update applied twice for one request");

   a_scan_then_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && stat.scan_done) |=> state_ff == S_APPLY)
      else $error("finished scan not followed by update");
endmodule

// ----- rtl/core/allocation_extent_tracker.sv -----
// An allocate or free request scans all 64 table slots through one RAM read port, then
// passes update, watermarks, divider setup, the divider steps and the output stage; the
// divider steps are skipped when the percent needs no division. Clear and code three skip
// the scan. The output stage waits while the previous result has not been taken.
// A new request is accepted in the cycle after the result is issued, not before.
// Synchronous reset empties the table and statistics and sets the space size to 0.
// Top level: ties the sequencer to the datapath. Depends on aet_pkg, aet_if,
// aet_ctrl and aet_datapath.
module allocation_extent_tracker (
   input  logic      clock,
   input  logic      reset,
   aet_req_if.sink   req_bus,
   aet_rsp_if.source rsp_bus,
   aet_csr_if.sink   csr_bus
);
   import aet_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   aet_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .stat          (stat),
      .cmd           (cmd)
   );

   aet_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .stat    (stat)
   );
endmodule

// ----- sim/tb_aet_scoreboard.sv -----
// Scoreboard class for the allocation extent tracker testbench: a predictor of the
// extent table and statistics plus a queue of expected results. Depends on aet_pkg.
package tb_aet_sb_pkg;
   import aet_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  allocated_bytes;
      logic [COUNT_W-1:0]  allocated_buffers;
      logic [TOTAL_W-1:0]  high_water_bytes;
      logic [TOTAL_W-1:0]  low_water_bytes;
      logic [SIZE_W-1:0]   min_extent_bytes;
      logic [SIZE_W-1:0]   max_extent_bytes;
      logic [ALLOC_W-1:0]  alloc_count;
      logic [PCT_W-1:0]    allocated_percent;
      logic [TOTAL_W-1:0]  pinned_bytes;
      logic [COUNT_W-1:0]  pinned_buffers;
   } stats_type;

   class extent_scoreboard;
      logic [ADDR_W-1:0]  tab_addr [TABLE_ENTRIES];
      logic [SIZE_W-1:0]  tab_size [TABLE_ENTRIES];
      bit                 tab_used [TABLE_ENTRIES];
      bit                 tab_pin  [TABLE_ENTRIES];
      logic [TOTAL_W-1:0] total, pin_total, hi_water, lo_water, space;
      logic [SIZE_W-1:0]  min_size, max_size;
      logic [ALLOC_W-1:0] n_alloc;
      logic [COUNT_W-1:0] n_buf, n_pin;
      stats_type          pending_stats [$];
      int                 errors;

      function new();
         space  = '0;
         errors = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (tab_used[i]) begin
            tab_used[i] = 0;
            tab_pin[i]  = 0;
         end
         total = '0; pin_total = '0; hi_water = '0; lo_water = '1;
         min_size = '1; max_size = '0; n_alloc = '0; n_buf = '0; n_pin = '0;
      endfunction

      function int lookup(logic [ADDR_W-1:0] a);
         foreach (tab_used[i])
            if (tab_used[i] && tab_addr[i] == a) return i;
         return -1;
      endfunction

      function int free_slot();
         foreach (tab_used[i])
            if (!tab_used[i]) return i;
         return -1;
      endfunction

      function void unlink(int i);
         total = total - TOTAL_W'(tab_size[i]);
         if (tab_pin[i]) begin
            pin_total = pin_total - TOTAL_W'(tab_size[i]);
            n_pin = n_pin - 1'b1;
         end
      endfunction

      function void watermarks();
         if (total < lo_water) lo_water = total;
         if (total > hi_water) hi_water = total;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                 logic [SIZE_W-1:0] sz, logic pin);
         stats_type s;
         logic [TOTAL_W+6:0] prod;
         int i;
         s.status = ST_DONE;
         if (op == OP_ALLOC) begin
            i = lookup(a);
            if (i < 0) begin
               i = free_slot();
               if (i >= 0) begin
                  tab_used[i] = 1;
                  tab_addr[i] = a;
                  n_buf = n_buf + 1'b1;
               end
            end else begin
               unlink(i);
            end
            if (i < 0) begin
               s.status = ST_FULL;
            end else begin
               tab_size[i] = sz;
               tab_pin[i]  = pin;
               total = total + TOTAL_W'(sz);
               if (pin) begin
                  pin_total = pin_total + TOTAL_W'(sz);
                  n_pin = n_pin + 1'b1;
               end
               n_alloc = n_alloc + 1'b1;
               if (sz < min_size) min_size = sz;
               if (sz > max_size) max_size = sz;
               watermarks();
            end
         end else if (op == OP_FREE) begin
            i = lookup(a);
            if (i < 0) begin
               s.status = ST_UNTRACKED;
            end else begin
               unlink(i);
               tab_used[i] = 0;
               tab_pin[i]  = 0;
               n_buf = n_buf - 1'b1;
               watermarks();
            end
         end else if (op == OP_CLEAR) begin
            wipe();
         end
         s.allocated_bytes   = total;
         s.allocated_buffers = n_buf;
         s.high_water_bytes  = hi_water;
         s.low_water_bytes   = lo_water;
         s.min_extent_bytes  = min_size;
         s.max_extent_bytes  = max_size;
         s.alloc_count       = n_alloc;
         s.pinned_bytes      = pin_total;
         s.pinned_buffers    = n_pin;
         if (space == 0) begin
            s.allocated_percent = '0;
         end else begin
            prod = (TOTAL_W+7)'(total) * 7'd100 / (TOTAL_W+7)'(space);
            s.allocated_percent = (prod > 100) ? PCT_MAX : PCT_W'(prod);
         end
         pending_stats.push_back(s);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("%0t: %s got %0h, want %0h", $realtime, what, got, want);
      endtask

      task check_result(stats_type g);
         stats_type w;
         if (pending_stats.size() == 0) begin
            report("unexpected result, status", g.status, 0);
            return;
         end
         w = pending_stats.pop_front();
         if (g.status !== w.status) report("status", g.status, w.status);
         if (g.allocated_bytes !== w.allocated_bytes)
            report("allocated_bytes", g.allocated_bytes, w.allocated_bytes);
         if (g.allocated_buffers !== w.allocated_buffers)
            report("allocated_buffers", g.allocated_buffers, w.allocated_buffers);
         if (g.high_water_bytes !== w.high_water_bytes)
            report("high_water_bytes", g.high_water_bytes, w.high_water_bytes);
         if (g.low_water_bytes !== w.low_water_bytes)
            report("low_water_bytes", g.low_water_bytes, w.low_water_bytes);
         if (g.min_extent_bytes !== w.min_extent_bytes)
            report("min_extent_bytes", g.min_extent_bytes, w.min_extent_bytes);
         if (g.max_extent_bytes !== w.max_extent_bytes)
            report("max_extent_bytes", g.max_extent_bytes, w.max_extent_bytes);
         if (g.alloc_count !== w.alloc_count)
            report("alloc_count", g.alloc_count, w.alloc_count);
         if (g.allocated_percent !== w.allocated_percent)
            report("allocated_percent", g.allocated_percent, w.allocated_percent);
         if (g.pinned_bytes !== w.pinned_bytes)
            report("pinned_bytes", g.pinned_bytes, w.pinned_bytes);
         if (g.pinned_buffers !== w.pinned_buffers)
            report("pinned_buffers", g.pinned_buffers, w.pinned_buffers);
      endtask
   endclass
endpackage

// ----- sim/tb_allocation_extent_tracker.sv -----
// Top-level testbench of allocation_extent_tracker: directed and random requests,
// random idling on both channels, register phases. Depends on aet_pkg, aet_if, the scoreboard.
module tb_allocation_extent_tracker;
   timeunit 1ns;
   timeprecision 1ps;
   import aet_pkg::*;
   import tb_aet_sb_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   stim_done = 0;
   bit   hold_rsp = 0;
   int   idle_cycles = 0;
   int   rsp_gap;
   logic [ADDR_W-1:0] addr_pool [16];

   aet_req_if req_bus ();
   aet_rsp_if rsp_bus ();
   aet_csr_if csr_bus ();

   extent_scoreboard sb = new();

   allocation_extent_tracker DUT (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.operation = OP_ALLOC;
      req_bus.extent_address = '0;
      req_bus.extent_bytes = '0;
      req_bus.pinned = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
   end

   task automatic idle(int n);
      repeat (n) @(posedge clock);
   endtask

   // Valid stays high into the next request when that one follows with no gap.
   task automatic send_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                               logic [SIZE_W-1:0] sz, logic pin);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         idle(gap);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.extent_address <= a;
      req_bus.extent_bytes <= sz;
      req_bus.pinned <= pin;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(op, a, sz, pin);
   endtask

   // Waits for every expected result to be checked, then idles the clock.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_stats.size() != 0) @(posedge clock);
      idle(100);
   endtask

   task automatic write_space(logic [TOTAL_W-1:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= v;
      do @(posedge clock); while (!csr_bus.ready);
      sb.space = v;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_request();
      int r;
      logic [SIZE_W-1:0] sz;
      logic [ADDR_W-1:0] a;
      logic pin;
      r = $urandom_range(0, 99);
      sz = ($urandom_range(0, 3) == 0) ? SIZE_W'({$urandom, $urandom})
                                       : SIZE_W'($urandom_range(0, 4096));
      a = ($urandom_range(0, 9) == 0) ? ADDR_W'({$urandom, $urandom})
                                      : addr_pool[$urandom_range(0, 15)];
      pin = 1'($urandom_range(0, 1));
      if (r < 55) send_request(OP_ALLOC, a, sz, pin);
      else if (r < 93) send_request(OP_FREE, a, sz, pin);
      else if (r < 97) send_request(OP_CLEAR, a, sz, pin);
      else send_request(OP_UNUSED, a, sz, pin);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            idle(400);
            hold_rsp = 0;
         end
         rsp_gap = $urandom_range(0, 6);
         if (rsp_gap != 0) begin
            rsp_bus.ready <= 1'b0;
            idle(rsp_gap);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         sb.check_result({rsp_bus.status, rsp_bus.allocated_bytes,
                          rsp_bus.allocated_buffers, rsp_bus.high_water_bytes,
                          rsp_bus.low_water_bytes, rsp_bus.min_extent_bytes,
                          rsp_bus.max_extent_bytes, rsp_bus.alloc_count,
                          rsp_bus.allocated_percent, rsp_bus.pinned_bytes,
                          rsp_bus.pinned_buffers});
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset
          || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      foreach (addr_pool[i]) addr_pool[i] = ADDR_W'({$urandom, $urandom});
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, repeats, untracked free, unused code, full table.
      write_space(48'd1000);
      send_request(OP_FREE, '1, '0, 1'b0);
      send_request(OP_ALLOC, '0, '0, 1'b0);
      send_request(OP_ALLOC, '1, '1, 1'b1);
      send_request(OP_ALLOC, '0, 40'd500, 1'b1);
      send_request(OP_ALLOC, '0, 40'd200, 1'b0);
      send_request(OP_FREE, '1, '0, 1'b0);
      send_request(OP_UNUSED, '1, '1, 1'b1);
      send_request(OP_ALLOC, 48'h5555_5555_5555, 40'd900, 1'b1);
      send_request(OP_CLEAR, '0, '0, 1'b0);
      for (int i = 0; i < 66; i++)
         send_request(OP_ALLOC, ADDR_W'(i + 100), 40'd7, i[0]);
      send_request(OP_FREE, 48'd105, '0, 1'b0);
      send_request(OP_ALLOC, 48'd999, 40'd3, 1'b1);
      drain();
      write_space('1);
      send_request(OP_ALLOC, 48'haaaa_aaaa_aaaa, '1, 1'b0);
      send_request(OP_CLEAR, '0, '0, 1'b0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_space('0);
            1: write_space(48'd4096);
            2: write_space(TOTAL_W'($urandom_range(1, 100000)));
            default: write_space(48'd1);
         endcase
         if (phase == 1) hold_rsp = 1;
         for (int n = 0; n < 450; n++) random_request();
         drain();
      end
      stim_done = 1;
      if (sb.errors == 0 && sb.pending_stats.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ----- allocation_extent_tracker.f -----
rtl/core/aet_pkg.sv
rtl/core/aet_if.sv
rtl/core/aet_ram.sv
rtl/core/aet_datapath.sv
rtl/core/aet_ctrl.sv
rtl/core/allocation_extent_tracker.sv
sim/tb_aet_scoreboard.sv
sim/tb_allocation_extent_tracker.sv
